>>> hdl/msgr_pkg.sv
// shared types, codes and constants of the mouse stroke gesture recognizer
`default_nettype none
package msgr_pkg;

  localparam int unsigned PATH_DEPTH_DEF = 10;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned THRESH_W       = 12;
  localparam logic [THRESH_W-1:0] THRESH_RST = 12'd100;

  typedef enum logic [2:0] {
    OP_MOVE  = 3'd0,
    OP_LDOWN = 3'd1,
    OP_RDOWN = 3'd2,
    OP_LUP   = 3'd3,
    OP_RUP   = 3'd4,
    OP_OTHER = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_BACK    = 3'd1,
    ACT_FORWARD = 3'd2,
    ACT_REFRESH = 3'd3,
    ACT_CLOSE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic scan_start;
    logic scan_step;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/msgr_if.sv
// valid/ready channels for mouse events and gesture results
`default_nettype none
interface msgr_evt_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          op;
  logic signed [msgr_pkg::COORD_W-1:0] cursor_x;
  logic signed [msgr_pkg::COORD_W-1:0] cursor_y;

  modport source (output valid, output op, output cursor_x, output cursor_y, input ready);
  modport sink   (input valid, input op, input cursor_x, input cursor_y, output ready);
endinterface

interface msgr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       send_escape;
  logic       consumed;

  modport source (output valid, output action, output send_escape, output consumed,
                  input ready);
  modport sink   (input valid, input action, input send_escape, input consumed,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/mouse_stroke_gesture_recognizer.sv
// top level of the mouse stroke gesture recognizer
// Takes one mouse event per transfer on evt_i and returns one result per event on res_o
// (action, escape flag, consumed flag). While the right button is held, moves that reach
// the stroke threshold on either axis are recorded as strokes in a PATH_DEPTH-entry
// stroke memory; a right release collapses repeated directions and matches the path,
// and rocker chords give back or forward at once. A right release that has to match the
// path scans the stroke memory through its single read port, one entry per cycle. The
// result sits in an output register, so a new event is taken while the previous result
// still waits. The threshold register (reset 100) is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while the block is idle, which the block
// itself does not enforce.
`default_nettype none
module mouse_stroke_gesture_recognizer #(
  parameter int unsigned PATH_DEPTH = msgr_pkg::PATH_DEPTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [msgr_pkg::THRESH_W-1:0]    cfg_wdata_i,
  msgr_evt_if.sink                         evt_i,
  msgr_res_if.source                       res_o
);

  msgr_pkg::cmd_t cmd;
  msgr_pkg::sts_t sts;

  msgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (evt_i.valid),
    .in_ready_o  (evt_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msgr_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (evt_i.op),
    .cursor_x_i    (evt_i.cursor_x),
    .cursor_y_i    (evt_i.cursor_y),
    .action_o      (res_o.action),
    .send_escape_o (res_o.send_escape),
    .consumed_o    (res_o.consumed)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.valid && evt_i.ready |=> !evt_i.ready)
    else $error("event taken while previous one still in progress");

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!res_o.valid || res_o.ready))
    else $error("result committed over a pending result");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  a_commit_after_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !evt_i.ready)
    else $error("commit while idle");
`endif

endmodule
`default_nettype wire

>>> hdl/msgr_ctrl.sv
// controller state machine: event sequencing, path scan and result slot
`default_nettype none
module msgr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  input  wire msgr_pkg::sts_t sts_i,
  output msgr_pkg::cmd_t      cmd_o
);

  msgr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      msgr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = msgr_pkg::ST_EXEC;
      end
      msgr_pkg::ST_EXEC: begin
        if (sts_i.need_scan) state_d = msgr_pkg::ST_SCAN;
        else if (slot_free) state_d = msgr_pkg::ST_IDLE;
      end
      msgr_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = msgr_pkg::ST_FIN;
      end
      msgr_pkg::ST_FIN: begin
        if (slot_free) state_d = msgr_pkg::ST_IDLE;
      end
      default: state_d = msgr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      msgr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      msgr_pkg::ST_EXEC: begin
        if (sts_i.need_scan) cmd_o.scan_start = 1'b1;
        else cmd_o.commit = slot_free;
      end
      msgr_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      msgr_pkg::ST_FIN: begin
        cmd_o.commit = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msgr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/msgr_dp.sv
// datapath: button and anchor state, stroke memory, path collapse and match
`default_nettype none
module msgr_dp #(
  parameter int unsigned PATH_DEPTH = msgr_pkg::PATH_DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire msgr_pkg::cmd_t                 cmd_i,
  output msgr_pkg::sts_t                      sts_o,
  input  wire                                 cfg_we_i,
  input  wire  [msgr_pkg::THRESH_W-1:0]       cfg_wdata_i,
  input  wire  [2:0]                          op_i,
  input  wire  signed [msgr_pkg::COORD_W-1:0] cursor_x_i,
  input  wire  signed [msgr_pkg::COORD_W-1:0] cursor_y_i,
  output logic [2:0]                          action_o,
  output logic                                send_escape_o,
  output logic                                consumed_o
);

  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
  localparam int unsigned AW = $clog2(PATH_DEPTH);
  localparam int unsigned XW = msgr_pkg::COORD_W;

  // latched event
  logic [2:0]           op_q;
  logic signed [XW-1:0] x_q, y_q;

  // tracking state
  logic [msgr_pkg::THRESH_W-1:0] thresh_q;
  logic                 right_held_q, right_held_d;
  logic                 left_held_q, left_held_d;
  logic                 taken_q, taken_d;
  logic signed [XW-1:0] anchor_x_q, anchor_x_d, anchor_y_q, anchor_y_d;
  logic [CW-1:0]        count_q, count_d;
  msgr_pkg::dir_e       last_dir_q, last_dir_d;

  // stroke memory
  msgr_pkg::dir_e       path_mem [PATH_DEPTH];
  logic                 mem_we;
  msgr_pkg::dir_e       rd_data_q;
  logic                 scan_rd;

  // scan state
  logic [CW-1:0]        scan_idx_q;
  logic                 rd_valid_q;
  logic [1:0]           runs_q;
  msgr_pkg::dir_e       first_q, second_q, slast_q;
  logic                 new_run;

  // move evaluation
  logic signed [XW:0]   dx, dy, ndx, ndy;
  logic [XW-1:0]        mag_x, mag_y;
  logic                 below;
  msgr_pkg::dir_e       dir;
  logic                 stroke_ok;

  // result
  msgr_pkg::action_e    match_act, res_act;
  logic                 res_esc, res_cons;

  assign dx    = {x_q[XW-1], x_q} - {anchor_x_q[XW-1], anchor_x_q};
  assign dy    = {y_q[XW-1], y_q} - {anchor_y_q[XW-1], anchor_y_q};
  assign ndx   = -dx;
  assign ndy   = -dy;
  assign mag_x = dx[XW] ? ndx[XW-1:0] : dx[XW-1:0];
  assign mag_y = dy[XW] ? ndy[XW-1:0] : dy[XW-1:0];
  assign below = (mag_x < {{(XW-msgr_pkg::THRESH_W){1'b0}}, thresh_q}) &&
                 (mag_y < {{(XW-msgr_pkg::THRESH_W){1'b0}}, thresh_q});

  always_comb begin
    if (mag_x > mag_y) begin
      dir = (!dx[XW] && (dx != '0)) ? msgr_pkg::DIR_RIGHT : msgr_pkg::DIR_LEFT;
    end else begin
      dir = (!dy[XW] && (dy != '0)) ? msgr_pkg::DIR_DOWN : msgr_pkg::DIR_UP;
    end
  end

  assign stroke_ok = right_held_q && (count_q < CW'(PATH_DEPTH)) && !below &&
                     !((count_q >= CW'(2)) && (last_dir_q == dir));

  // gesture table on the collapsed path
  always_comb begin
    match_act = msgr_pkg::ACT_NONE;
    if (runs_q == 2'd1) begin
      if (first_q == msgr_pkg::DIR_LEFT) match_act = msgr_pkg::ACT_BACK;
      else if (first_q == msgr_pkg::DIR_RIGHT) match_act = msgr_pkg::ACT_FORWARD;
    end else if (runs_q == 2'd2) begin
      if (first_q == msgr_pkg::DIR_UP && second_q == msgr_pkg::DIR_DOWN) begin
        match_act = msgr_pkg::ACT_REFRESH;
      end else if (first_q == msgr_pkg::DIR_DOWN && second_q == msgr_pkg::DIR_RIGHT) begin
        match_act = msgr_pkg::ACT_CLOSE;
      end
    end
  end

  always_comb begin
    res_act      = msgr_pkg::ACT_NONE;
    res_esc      = 1'b0;
    res_cons     = 1'b0;
    right_held_d = right_held_q;
    left_held_d  = left_held_q;
    taken_d      = taken_q;
    anchor_x_d   = anchor_x_q;
    anchor_y_d   = anchor_y_q;
    count_d      = count_q;
    last_dir_d   = last_dir_q;
    mem_we       = 1'b0;
    case (op_q)
      msgr_pkg::OP_MOVE: begin
        if (stroke_ok) begin
          mem_we     = 1'b1;
          count_d    = count_q + CW'(1);
          anchor_x_d = x_q;
          anchor_y_d = y_q;
          last_dir_d = dir;
        end
      end
      msgr_pkg::OP_LDOWN: begin
        left_held_d = 1'b1;
        if (right_held_q) begin
          res_act  = msgr_pkg::ACT_BACK;
          res_cons = 1'b1;
          count_d  = '0;
          taken_d  = 1'b1;
        end else begin
          taken_d = 1'b0;
        end
      end
      msgr_pkg::OP_RDOWN: begin
        right_held_d = 1'b1;
        count_d      = '0;
        if (left_held_q) begin
          res_act  = msgr_pkg::ACT_FORWARD;
          res_cons = 1'b1;
          taken_d  = 1'b1;
        end else begin
          anchor_x_d = x_q;
          anchor_y_d = y_q;
          taken_d    = 1'b0;
        end
      end
      msgr_pkg::OP_LUP: begin
        left_held_d = 1'b0;
        if (right_held_q) begin
          res_esc  = 1'b1;
          res_cons = 1'b1;
          taken_d  = 1'b1;
        end else begin
          taken_d = 1'b0;
        end
      end
      msgr_pkg::OP_RUP: begin
        right_held_d = 1'b0;
        count_d      = '0;
        taken_d      = 1'b0;
        if (taken_q) begin
          res_esc  = 1'b1;
          res_cons = 1'b1;
        end else begin
          res_act  = match_act;
          res_esc  = (match_act != msgr_pkg::ACT_NONE);
          res_cons = (match_act != msgr_pkg::ACT_NONE);
        end
      end
      default: begin
        res_act = msgr_pkg::ACT_NONE;
      end
    endcase
  end

  assign sts_o.need_scan = (op_q == msgr_pkg::OP_RUP) && !taken_q;
  assign sts_o.scan_done = (scan_idx_q == count_q) && !rd_valid_q;

  assign scan_rd = cmd_i.scan_step && (scan_idx_q < count_q);
  assign new_run = (runs_q == 2'd0) || (rd_data_q != slast_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) path_mem[count_q[AW-1:0]] <= last_dir_d;
    if (scan_rd) rd_data_q <= path_mem[scan_idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      x_q  <= cursor_x_i;
      y_q  <= cursor_y_i;
    end
    if (cmd_i.scan_step && rd_valid_q && new_run) begin
      if (runs_q == 2'd0) first_q <= rd_data_q;
      else if (runs_q == 2'd1) second_q <= rd_data_q;
      slast_q <= rd_data_q;
    end
    if (cmd_i.commit) begin
      action_o      <= res_act;
      send_escape_o <= res_esc;
      consumed_o    <= res_cons;
      last_dir_q    <= last_dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q     <= msgr_pkg::THRESH_RST;
      right_held_q <= 1'b0;
      left_held_q  <= 1'b0;
      taken_q      <= 1'b0;
      anchor_x_q   <= '0;
      anchor_y_q   <= '0;
      count_q      <= '0;
      scan_idx_q   <= '0;
      rd_valid_q   <= 1'b0;
      runs_q       <= '0;
    end else begin
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        right_held_q <= right_held_d;
        left_held_q  <= left_held_d;
        taken_q      <= taken_d;
        anchor_x_q   <= anchor_x_d;
        anchor_y_q   <= anchor_y_d;
        count_q      <= count_d;
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        rd_valid_q <= 1'b0;
        runs_q     <= '0;
      end else if (cmd_i.scan_step) begin
        if (scan_rd) scan_idx_q <= scan_idx_q + CW'(1);
        rd_valid_q <= scan_rd;
        if (rd_valid_q && new_run && (runs_q != 2'd3)) runs_q <= runs_q + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sim/mouse_stroke_gesture_recognizer_test.sv
// self-checking testbench for the mouse stroke gesture recognizer
`timescale 1ns / 100ps
module mouse_stroke_gesture_recognizer_test;
  import msgr_pkg::*;

  localparam int unsigned DEPTH = PATH_DEPTH_DEF;
  localparam int PHASE_EVENTS = 130;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    action_e action;
    logic    send_escape;
    logic    consumed;
  } gesture_res_t;

  typedef struct {
    logic [2:0]   op;
    int           x;
    int           y;
    bit           typed;
    gesture_res_t res;
  } script_row_t;

  localparam gesture_res_t PASS_ON  = '{ACT_NONE, 1'b0, 1'b0};
  localparam gesture_res_t ESC_ONLY = '{ACT_NONE, 1'b1, 1'b1};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [THRESH_W-1:0] cfg_wdata_i;

  msgr_evt_if evt_ch ();
  msgr_res_if res_ch ();

  mouse_stroke_gesture_recognizer #(
    .PATH_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt_i      (evt_ch),
    .res_o      (res_ch)
  );

  // predictor state
  bit                  rbtn_down;
  bit                  lbtn_down;
  bit                  chord_fired;
  logic signed [15:0]  mark_x = '0;
  logic signed [15:0]  mark_y = '0;
  dir_e                strokes [DEPTH];
  int                  n_strokes;
  logic [THRESH_W-1:0] stroke_min = THRESH_RST;

  gesture_res_t awaited_gestures [$];
  gesture_res_t oldest;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           events_sent = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_left = 0;

  script_row_t script_rows [28] = '{
    '{OP_MOVE,         0,      0, 1'b1, PASS_ON},
    '{OP_OTHER,    32767, -32768, 1'b1, PASS_ON},
    '{OP_SPARE_A,     -1,     -1, 1'b1, PASS_ON},
    '{OP_SPARE_B, -32768,  32767, 1'b1, PASS_ON},
    // two left strokes, third repeat dropped, collapses to back
    '{OP_RDOWN,        0,      0, 1'b1, PASS_ON},
    '{OP_MOVE,      -150,     10, 1'b0, PASS_ON},
    '{OP_MOVE,      -250,     10, 1'b0, PASS_ON},
    '{OP_MOVE,      -350,     10, 1'b0, PASS_ON},
    '{OP_RUP,       -350,     10, 1'b1, '{ACT_BACK, 1'b1, 1'b1}},
    '{OP_RDOWN,        0,      0, 1'b0, PASS_ON},
    '{OP_MOVE,         0,   -100, 1'b0, PASS_ON},
    '{OP_MOVE,         0,    100, 1'b0, PASS_ON},
    '{OP_RUP,          0,    100, 1'b1, '{ACT_REFRESH, 1'b1, 1'b1}},
    // diagonal tie counts as down
    '{OP_RDOWN,        0,      0, 1'b0, PASS_ON},
    '{OP_MOVE,       100,    100, 1'b0, PASS_ON},
    '{OP_MOVE,       200,    100, 1'b0, PASS_ON},
    '{OP_RUP,        200,    100, 1'b1, '{ACT_CLOSE, 1'b1, 1'b1}},
    // rocker chords
    '{OP_LDOWN,        0,      0, 1'b1, PASS_ON},
    '{OP_RDOWN,        0,      0, 1'b1, '{ACT_FORWARD, 1'b0, 1'b1}},
    '{OP_LUP,          0,      0, 1'b1, ESC_ONLY},
    '{OP_RUP,          0,      0, 1'b1, ESC_ONLY},
    '{OP_RDOWN,   -32768, -32768, 1'b1, PASS_ON},
    '{OP_LDOWN,   -32768, -32768, 1'b1, '{ACT_BACK, 1'b0, 1'b1}},
    '{OP_LUP,     -32768, -32768, 1'b1, ESC_ONLY},
    '{OP_RUP,     -32768, -32768, 1'b1, ESC_ONLY},
    '{OP_RDOWN,   -32768,      0, 1'b0, PASS_ON},
    '{OP_MOVE,     32767,      0, 1'b0, PASS_ON},
    '{OP_RUP,      32767,      0, 1'b1, '{ACT_FORWARD, 1'b1, 1'b1}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic gesture_res_t recognize(input logic [2:0] op,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y);
    gesture_res_t r;
    int           dx;
    int           dy;
    int           mx;
    int           my;
    int           runs;
    dir_e         dir;
    dir_e         first;
    dir_e         second;
    dir_e         last_dir;
    r = PASS_ON;
    case (op)
      OP_MOVE: begin
        if (rbtn_down && n_strokes < DEPTH) begin
          dx = int'(x) - int'(mark_x);
          dy = int'(y) - int'(mark_y);
          mx = (dx < 0) ? -dx : dx;
          my = (dy < 0) ? -dy : dy;
          if (mx >= int'(stroke_min) || my >= int'(stroke_min)) begin
            if (mx > my) dir = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
            else dir = (dy > 0) ? DIR_DOWN : DIR_UP;
            if (!(n_strokes >= 2 && strokes[n_strokes-1] == dir)) begin
              strokes[n_strokes] = dir;
              n_strokes++;
              mark_x = x;
              mark_y = y;
            end
          end
        end
      end
      OP_LDOWN: begin
        lbtn_down = 1'b1;
        if (rbtn_down) begin
          r.action = ACT_BACK;
          r.consumed = 1'b1;
          n_strokes = 0;
          chord_fired = 1'b1;
        end else begin
          chord_fired = 1'b0;
        end
      end
      OP_RDOWN: begin
        rbtn_down = 1'b1;
        if (lbtn_down) begin
          r.action = ACT_FORWARD;
          r.consumed = 1'b1;
          n_strokes = 0;
          chord_fired = 1'b1;
        end else begin
          mark_x = x;
          mark_y = y;
          n_strokes = 0;
          chord_fired = 1'b0;
        end
      end
      OP_LUP: begin
        lbtn_down = 1'b0;
        if (rbtn_down) begin
          r.send_escape = 1'b1;
          r.consumed = 1'b1;
          chord_fired = 1'b1;
        end else begin
          chord_fired = 1'b0;
        end
      end
      OP_RUP: begin
        rbtn_down = 1'b0;
        if (chord_fired) begin
          r.send_escape = 1'b1;
          r.consumed = 1'b1;
        end else begin
          // collapse runs and keep the first two directions
          runs = 0;
          first = DIR_RIGHT;
          second = DIR_RIGHT;
          last_dir = DIR_RIGHT;
          for (int i = 0; i < n_strokes; i++) begin
            if (runs == 0 || strokes[i] != last_dir) begin
              if (runs == 0) first = strokes[i];
              else if (runs == 1) second = strokes[i];
              runs++;
              last_dir = strokes[i];
            end
          end
          if (runs == 1 && first == DIR_LEFT) r.action = ACT_BACK;
          else if (runs == 1 && first == DIR_RIGHT) r.action = ACT_FORWARD;
          else if (runs == 2 && first == DIR_UP && second == DIR_DOWN) r.action = ACT_REFRESH;
          else if (runs == 2 && first == DIR_DOWN && second == DIR_RIGHT) r.action = ACT_CLOSE;
          if (r.action != ACT_NONE) begin
            r.send_escape = 1'b1;
            r.consumed = 1'b1;
          end
        end
        n_strokes = 0;
        chord_fired = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (awaited_gestures.size() == 0) begin
        report_mismatch("result transfer with no event pending");
      end else begin
        oldest = awaited_gestures.pop_front();
        if (res_ch.action !== oldest.action)
          report_mismatch($sformatf("action %0d, expected %0d", res_ch.action, oldest.action));
        if (res_ch.send_escape !== oldest.send_escape)
          report_mismatch($sformatf("send_escape %0b, expected %0b", res_ch.send_escape,
                                    oldest.send_escape));
        if (res_ch.consumed !== oldest.consumed)
          report_mismatch($sformatf("consumed %0b, expected %0b", res_ch.consumed,
                                    oldest.consumed));
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  task automatic send_event(input logic [2:0] op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input bit typed = 1'b0,
                            input gesture_res_t typed_res = PASS_ON);
    gesture_res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.op <= op;
    evt_ch.cursor_x <= x;
    evt_ch.cursor_y <= y;
    do @(posedge clk_i); while (!evt_ch.ready);
    predicted = recognize(op, x, y);
    awaited_gestures.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i) evt_ch.valid <= 1'b0;
    while (awaited_gestures.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // right press, a planned path of strokes with jitter, right release
  task automatic send_gesture();
    logic signed [15:0] bx;
    logic signed [15:0] by;
    dir_e               plan [$];
    int                 d;
    int                 c;
    int                 j;
    int                 pick;
    bx = 16'($urandom);
    by = 16'($urandom);
    send_event(OP_RDOWN, bx, by);
    case ($urandom_range(0, 5))
      0: plan = '{DIR_LEFT};
      1: plan = '{DIR_RIGHT};
      2: plan = '{DIR_UP, DIR_DOWN};
      3: plan = '{DIR_DOWN, DIR_RIGHT};
      default: begin
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4))
          plan.push_back(dir_e'($urandom_range(0, 3)));
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, plan.size() - 1);
      plan.insert(pick, plan[pick]);
    end
    foreach (plan[i]) begin
      if (stroke_min > 1 && $urandom_range(0, 2) == 0) begin
        j = $urandom_range(0, stroke_min - 1);
        send_event(OP_MOVE, bx + 16'(j), by - 16'(j / 2));
      end
      d = int'(stroke_min) + $urandom_range(0, 40);
      case ($urandom_range(0, 7))
        0: d = int'(stroke_min);
        1: if (stroke_min > 0) d = int'(stroke_min) - 1;
        default: ;
      endcase
      c = $urandom_range(0, d);
      if ($urandom_range(0, 1) == 1) c = -c;
      case (plan[i])
        DIR_RIGHT: begin bx = bx + 16'(d); by = by + 16'(c); end
        DIR_LEFT:  begin bx = bx - 16'(d); by = by + 16'(c); end
        DIR_UP:    begin by = by - 16'(d); bx = bx + 16'(c); end
        default:   begin by = by + 16'(d); bx = bx + 16'(c); end
      endcase
      send_event(OP_MOVE, bx, by);
      if ($urandom_range(0, 24) == 0)
        send_event(($urandom_range(0, 1) == 1) ? OP_LDOWN : OP_LUP, bx, by);
    end
    send_event(OP_RUP, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(input logic [THRESH_W-1:0] thr, input int idle_pct,
                           input int stall_pct, input bit squeeze);
    int  start;
    bit  held;
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    stroke_min = thr;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = events_sent;
    held = 1'b0;
    while (events_sent - start < PHASE_EVENTS) begin
      if (squeeze && !held && events_sent - start >= PHASE_EVENTS / 2) begin
        hold_left = HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) send_gesture();
      else send_event(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    evt_ch.valid = 1'b0;
    evt_ch.op = OP_MOVE;
    evt_ch.cursor_x = '0;
    evt_ch.cursor_y = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (script_rows[i])
      send_event(script_rows[i].op, 16'(script_rows[i].x), 16'(script_rows[i].y),
                 script_rows[i].typed, script_rows[i].res);

    run_phase(12'd1, 0, 0, 1'b0);
    run_phase(12'd4095, 84, 0, 1'b0);
    run_phase(12'($urandom_range(2, 300)), 0, 84, 1'b0);
    run_phase(12'd0, 25, 25, 1'b0);
    run_phase(THRESH_RST, 0, 0, 1'b1);

    wait_idle();
    if (mismatches == 0 && awaited_gestures.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/msgr_pkg.sv
hdl/msgr_if.sv
hdl/msgr_ctrl.sv
hdl/msgr_dp.sv
hdl/mouse_stroke_gesture_recognizer.sv
sim/mouse_stroke_gesture_recognizer_test.sv
